/* hw/rtl/whtni_pkg.sv */
package whtni_pkg;

	localparam int MaxIcons   = 64;
	localparam int MaxRegions = 32;
	localparam int CoordBits  = 10;

	typedef enum logic [1:0] {
		OP_ADD_ICON   = 2'd0,
		OP_ADD_REGION = 2'd1,
		OP_CLICK      = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	localparam logic [1:0] KIND_REGION = 2'd0;
	localparam logic [1:0] KIND_ICON   = 2'd1;
	localparam logic [1:0] KIND_NONE   = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic [9:0] x_first;
		logic [9:0] y_first;
		logic [9:0] x_second;
		logic [9:0] y_second;
	} cmd_t;

	typedef struct packed {
		logic [1:0] hit_kind;
		logic [5:0] hit_index;
		logic       last_of_run;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RSCAN,
		ST_RWAIT,
		ST_IFETCH,
		ST_HSCAN,
		ST_HWAIT,
		ST_DIST,
		ST_NEXT,
		ST_NONE,
		ST_FLUSH
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;       // latch command, load region index with region count
		logic reg_step;   // advance region index
		logic icon_init;  // restart icon scan
		logic icon_step;  // advance icon index
		logic hid_init;   // restart hiding scan for current icon
		logic hid_step;   // advance hiding region index
		logic hid_sel;    // region read port addressed by the hiding index
		logic dist_eval;  // compare distance of current icon
		logic emit_none;
		logic emit_region;
		logic flush;      // emit pending icon with last flag
		logic pass2;      // second pass active
	} ctl_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_click;
		logic reg_done;   // region index exhausted
		logic reg_hit;    // region at index holds click (registered read valid)
		logic icon_done;
		logic hid_done;
		logic hid_hit;
		logic found;
	} sts_t;

endpackage

/* hw/rtl/whtni_dp.sv */
module whtni_dp #(
	parameter int MAX_ICONS   = whtni_pkg::MaxIcons,
	parameter int MAX_REGIONS = whtni_pkg::MaxRegions
) (
	input  logic                clk,
	input  logic                arst_n,
	input  whtni_pkg::cmd_t     cmd,
	input  logic                accept,
	input  whtni_pkg::ctl_t     ctl,
	output whtni_pkg::sts_t     sts,
	output logic                res_valid,
	output whtni_pkg::result_t  res
);
	localparam int CB = whtni_pkg::CoordBits;
	localparam int IW = (MAX_ICONS > 1) ? $clog2(MAX_ICONS) : 1;
	localparam int RW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int IC = $clog2(MAX_ICONS + 1);
	localparam int RC = $clog2(MAX_REGIONS + 1);
	localparam int DW = 2 * CB + 1;

	logic [CB-1:0] ix_mem [MAX_ICONS];
	logic [CB-1:0] iy_mem [MAX_ICONS];
	logic [CB-1:0] rl_mem [MAX_REGIONS];
	logic [CB-1:0] rt_mem [MAX_REGIONS];
	logic [CB-1:0] rr_mem [MAX_REGIONS];
	logic [CB-1:0] rb_mem [MAX_REGIONS];

	logic [IC-1:0] icon_cnt_q;
	logic [RC-1:0] reg_cnt_q;
	logic [CB-1:0] cx_q, cy_q;
	logic is_click_q;
	logic [RC-1:0] ridx_q;   // counts down, region = ridx_q - 1
	logic [IC-1:0] iidx_q;
	logic [RC-1:0] hidx_q;
	logic [CB-1:0] rl_q, rt_q, rr_q, rb_q;
	logic [CB-1:0] ix_q, iy_q;
	logic [DW-1:0] dx2_q, dy2_q;
	logic [DW-1:0] best_q;
	logic found_q;
	logic pend_q;
	logic [IW-1:0] pend_idx_q;
	logic [RW-1:0] rd_addr;
	logic [DW-1:0] dist_sum;
	logic [CB-1:0] adx, ady;
	logic emit;
	whtni_pkg::result_t res_d;

	wire [CB-1:0] ax = cmd.x_first[CB-1:0];
	wire [CB-1:0] ay = cmd.y_first[CB-1:0];

	// Stores.
	always_ff @(posedge clk) begin
		if (accept && cmd.operation == whtni_pkg::OP_ADD_ICON
				&& icon_cnt_q < IC'(MAX_ICONS)) begin
			ix_mem[icon_cnt_q[IW-1:0]] <= ax;
			iy_mem[icon_cnt_q[IW-1:0]] <= ay;
		end
		if (accept && cmd.operation == whtni_pkg::OP_ADD_REGION
				&& reg_cnt_q < RC'(MAX_REGIONS)) begin
			rl_mem[reg_cnt_q[RW-1:0]] <= ax;
			rt_mem[reg_cnt_q[RW-1:0]] <= ay;
			rr_mem[reg_cnt_q[RW-1:0]] <= cmd.x_second[CB-1:0];
			rb_mem[reg_cnt_q[RW-1:0]] <= cmd.y_second[CB-1:0];
		end
	end

	// One region read port, shared by click scan and hiding scan.
	always_comb begin
		if (ctl.hid_sel)
			rd_addr = hidx_q[RW-1:0];
		else
			rd_addr = RW'(ridx_q - RC'(1));
	end

	always_ff @(posedge clk) begin
		rl_q <= rl_mem[rd_addr];
		rt_q <= rt_mem[rd_addr];
		rr_q <= rr_mem[rd_addr];
		rb_q <= rb_mem[rd_addr];
		ix_q <= ix_mem[iidx_q[IW-1:0]];
		iy_q <= iy_mem[iidx_q[IW-1:0]];
	end

	// A pass-two match releases the previously held match, so the final one
	// can still be given the last flag when the pass ends.
	always_comb begin
		emit = 1'b0;
		res_d = '0;
		if (ctl.dist_eval && ctl.pass2 && dist_sum == best_q && pend_q) begin
			emit = 1'b1;
			res_d = '{whtni_pkg::KIND_ICON, 6'(pend_idx_q), 1'b0};
		end else if (ctl.flush) begin
			emit = 1'b1;
			res_d = '{whtni_pkg::KIND_ICON, 6'(pend_idx_q), 1'b1};
		end else if (ctl.emit_none) begin
			emit = 1'b1;
			res_d = '{whtni_pkg::KIND_NONE, 6'd0, 1'b1};
		end else if (ctl.emit_region) begin
			emit = 1'b1;
			res_d = '{whtni_pkg::KIND_REGION, 6'(ridx_q - RC'(1)), 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icon_cnt_q <= '0;
			reg_cnt_q  <= '0;
			is_click_q <= 1'b0;
			ridx_q     <= '0;
			iidx_q     <= '0;
			hidx_q     <= '0;
			best_q     <= '0;
			found_q    <= 1'b0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
			res_valid  <= 1'b0;
			res        <= '0;
		end else begin
			res_valid <= emit;
			if (emit)
				res <= res_d;
			if (accept && cmd.operation == whtni_pkg::OP_ADD_ICON
					&& icon_cnt_q < IC'(MAX_ICONS))
				icon_cnt_q <= icon_cnt_q + IC'(1);
			if (accept && cmd.operation == whtni_pkg::OP_ADD_REGION
					&& reg_cnt_q < RC'(MAX_REGIONS))
				reg_cnt_q <= reg_cnt_q + RC'(1);
			if (ctl.load) begin
				is_click_q <= (cmd.operation == whtni_pkg::OP_CLICK);
				ridx_q <= reg_cnt_q;
				found_q <= 1'b0;
				pend_q <= 1'b0;
			end
			if (ctl.reg_step)
				ridx_q <= ridx_q - RC'(1);
			if (ctl.icon_init)
				iidx_q <= '0;
			if (ctl.icon_step)
				iidx_q <= iidx_q + IC'(1);
			if (ctl.hid_init)
				hidx_q <= '0;
			if (ctl.hid_step)
				hidx_q <= hidx_q + RC'(1);
			if (ctl.dist_eval) begin
				if (!ctl.pass2) begin
					if (!found_q || dist_sum < best_q)
						best_q <= dist_sum;
					found_q <= 1'b1;
				end else if (dist_sum == best_q) begin
					pend_q <= 1'b1;
					pend_idx_q <= iidx_q[IW-1:0];
				end
			end
			if (ctl.flush)
				pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cx_q <= ax;
			cy_q <= ay;
		end
		// Squares registered before the add.
		dx2_q <= DW'(adx) * DW'(adx);
		dy2_q <= DW'(ady) * DW'(ady);
	end

	assign adx = (cx_q > ix_q) ? cx_q - ix_q : ix_q - cx_q;
	assign ady = (cy_q > iy_q) ? cy_q - iy_q : iy_q - cy_q;
	assign dist_sum = dx2_q + dy2_q;

	assign sts.is_click  = is_click_q;
	assign sts.reg_done  = (ridx_q == '0);
	assign sts.reg_hit   = cx_q >= rl_q && cx_q <= rr_q
		&& cy_q >= rt_q && cy_q <= rb_q;
	assign sts.icon_done = (iidx_q >= icon_cnt_q);
	assign sts.hid_done  = (hidx_q >= reg_cnt_q);
	assign sts.hid_hit   = ix_q >= rl_q && ix_q <= rr_q
		&& iy_q >= rt_q && iy_q <= rb_q;
	assign sts.found     = found_q;
endmodule

/* hw/rtl/whtni_ctrl.sv */
module whtni_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  whtni_pkg::sts_t sts,
	output logic            busy,
	output whtni_pkg::ctl_t ctl
);
	whtni_pkg::state_t state_q, state_d;
	logic pass2_q, pass2_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= whtni_pkg::ST_IDLE;
			pass2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pass2_q <= pass2_d;
		end
	end

	// Sequence: DECODE issues the read of the newest region, RWAIT tests it and
	// RSCAN issues the next one. For each icon IFETCH reads the icon, HSCAN/HWAIT
	// walk the regions until one covers it, DIST compares the distance once the squares are ready.
	always_comb begin
		state_d = state_q;
		pass2_d = pass2_q;
		unique case (state_q)
			whtni_pkg::ST_IDLE: begin
				if (start) state_d = whtni_pkg::ST_DECODE;
			end
			whtni_pkg::ST_DECODE: begin
				if (!sts.is_click) state_d = whtni_pkg::ST_IDLE;
				else if (sts.reg_done) state_d = whtni_pkg::ST_IFETCH;
				else state_d = whtni_pkg::ST_RWAIT;
			end
			whtni_pkg::ST_RSCAN: begin
				if (sts.reg_done) state_d = whtni_pkg::ST_IFETCH;
				else state_d = whtni_pkg::ST_RWAIT;
			end
			whtni_pkg::ST_RWAIT: begin
				if (sts.reg_hit) state_d = whtni_pkg::ST_IDLE;
				else state_d = whtni_pkg::ST_RSCAN;
			end
			whtni_pkg::ST_IFETCH: begin
				if (sts.icon_done) begin
					if (pass2_q) state_d = whtni_pkg::ST_FLUSH;
					else if (!sts.found) state_d = whtni_pkg::ST_NONE;
					else begin
						pass2_d = 1'b1;
						state_d = whtni_pkg::ST_IFETCH;
					end
				end else state_d = whtni_pkg::ST_HSCAN;
			end
			whtni_pkg::ST_HSCAN: begin
				if (sts.hid_done) state_d = whtni_pkg::ST_DIST;
				else state_d = whtni_pkg::ST_HWAIT;
			end
			whtni_pkg::ST_HWAIT: begin
				if (sts.hid_hit) state_d = whtni_pkg::ST_NEXT;
				else state_d = whtni_pkg::ST_HSCAN;
			end
			whtni_pkg::ST_DIST: state_d = whtni_pkg::ST_NEXT;
			whtni_pkg::ST_NEXT: state_d = whtni_pkg::ST_IFETCH;
			whtni_pkg::ST_NONE: state_d = whtni_pkg::ST_IDLE;
			whtni_pkg::ST_FLUSH: begin
				pass2_d = 1'b0;
				state_d = whtni_pkg::ST_IDLE;
			end
			default: state_d = whtni_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		busy = (state_q != whtni_pkg::ST_IDLE);
		ctl.pass2 = pass2_q;
		unique case (state_q)
			whtni_pkg::ST_IDLE: ctl.load = start;
			whtni_pkg::ST_DECODE: ctl.icon_init = 1'b1;
			whtni_pkg::ST_RSCAN: ;
			whtni_pkg::ST_RWAIT: begin
				ctl.emit_region = sts.reg_hit;
				ctl.reg_step = !sts.reg_hit;
			end
			whtni_pkg::ST_IFETCH: begin
				ctl.hid_init = 1'b1;
				ctl.icon_init = sts.icon_done && !pass2_q && sts.found;
			end
			whtni_pkg::ST_HSCAN: ctl.hid_sel = 1'b1;
			whtni_pkg::ST_HWAIT: ctl.hid_step = !sts.hid_hit;
			whtni_pkg::ST_DIST: ctl.dist_eval = 1'b1;
			whtni_pkg::ST_NEXT: ctl.icon_step = 1'b1;
			whtni_pkg::ST_NONE: ctl.emit_none = 1'b1;
			whtni_pkg::ST_FLUSH: ctl.flush = 1'b1;
			default: ;
		endcase
	end
endmodule

/* hw/rtl/window_hit_test_nearest_icon.sv */
// Adds and other non-click commands keep busy high for one cycle after the
// accepting edge. A click first decodes, then tests each stored region from the
// newest down; a region hit gives its one result and ends the click. Otherwise
// two passes run over the stored icons: a visible icon is tested against every
// stored region for the hiding test, a hidden icon stops at the first region
// that covers it, and a final state gives the last or the none result; regions
// are read one at a time through the single region read port. Results appear as
// one-cycle strobes that the receiver cannot stall, and busy falls in the cycle
// that carries the final result.
module window_hit_test_nearest_icon #(
	parameter int MAX_ICONS   = whtni_pkg::MaxIcons,
	parameter int MAX_REGIONS = whtni_pkg::MaxRegions
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  whtni_pkg::cmd_t    cmd,
	output logic               result_valid,
	output whtni_pkg::result_t result
);
	whtni_pkg::ctl_t ctl;
	whtni_pkg::sts_t sts;

	whtni_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .busy(busy), .ctl(ctl)
	);

	whtni_dp #(
		.MAX_ICONS(MAX_ICONS), .MAX_REGIONS(MAX_REGIONS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .accept(start && !busy), .ctl(ctl),
		.sts(sts), .res_valid(result_valid), .res(result)
	);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("not busy after start");
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.hit_kind != whtni_pkg::KIND_ICON |-> result.last_of_run)
		else $error("single result without last flag");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(busy) |-> !result_valid) else $error("result while idle");
endmodule

/* bench/tb_window_hit_test_nearest_icon.sv */
`timescale 1ns / 1ps

module tb_window_hit_test_nearest_icon;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	whtni_pkg::cmd_t    cmd;
	logic               result_valid;
	whtni_pkg::result_t result;

	window_hit_test_nearest_icon i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_valid(result_valid),
		.result(result)
	);

	// Shadow copy of the icon and region stores.
	logic [9:0] icon_x [whtni_pkg::MaxIcons];
	logic [9:0] icon_y [whtni_pkg::MaxIcons];
	int         num_icons;
	logic [9:0] reg_left   [whtni_pkg::MaxRegions];
	logic [9:0] reg_top    [whtni_pkg::MaxRegions];
	logic [9:0] reg_right  [whtni_pkg::MaxRegions];
	logic [9:0] reg_bottom [whtni_pkg::MaxRegions];
	int         num_regions;

	whtni_pkg::cmd_t    pending_cmds[$];
	whtni_pkg::result_t expected_hits[$];
	int                 errors;
	bit                 calm;

	function automatic bit point_in_region(int r, logic [9:0] x, logic [9:0] y);
		return x >= reg_left[r] && x <= reg_right[r] && y >= reg_top[r] && y <= reg_bottom[r];
	endfunction

	function automatic bit icon_hidden(int i);
		for (int r = 0; r < num_regions; r++)
			if (point_in_region(r, icon_x[i], icon_y[i]))
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic int sq_dist(logic [9:0] ax, logic [9:0] ay, int i);
		int dx;
		int dy;
		dx = int'(ax) - int'(icon_x[i]);
		dy = int'(ay) - int'(icon_y[i]);
		return dx * dx + dy * dy;
	endfunction

	task automatic queue_cmd(whtni_pkg::cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	task automatic expect_hit(logic [1:0] kind, int index, bit last);
		whtni_pkg::result_t res;
		res.hit_kind = kind;
		res.hit_index = 6'(index);
		res.last_of_run = last;
		expected_hits.insert(expected_hits.size(), res);
	endtask

	task automatic predict_hits(whtni_pkg::cmd_t c);
		int best;
		bit found;
		int last_idx;
		found = 1'b0;
		best = 0;
		last_idx = 0;
		case (whtni_pkg::op_t'(c.operation))
			whtni_pkg::OP_ADD_ICON: begin
				if (num_icons < whtni_pkg::MaxIcons) begin
					icon_x[num_icons] = c.x_first;
					icon_y[num_icons] = c.y_first;
					num_icons++;
				end
			end
			whtni_pkg::OP_ADD_REGION: begin
				if (num_regions < whtni_pkg::MaxRegions) begin
					reg_left[num_regions] = c.x_first;
					reg_top[num_regions] = c.y_first;
					reg_right[num_regions] = c.x_second;
					reg_bottom[num_regions] = c.y_second;
					num_regions++;
				end
			end
			whtni_pkg::OP_CLICK: begin
				for (int r = num_regions - 1; r >= 0; r--) begin
					if (point_in_region(r, c.x_first, c.y_first)) begin
						expect_hit(whtni_pkg::KIND_REGION, r, 1'b1);
						return;
					end
				end
				for (int i = 0; i < num_icons; i++) begin
					if (!icon_hidden(i) &&
							(!found || sq_dist(c.x_first, c.y_first, i) < best)) begin
						best = sq_dist(c.x_first, c.y_first, i);
						found = 1'b1;
					end
				end
				if (!found) begin
					expect_hit(whtni_pkg::KIND_NONE, 0, 1'b1);
					return;
				end
				for (int i = 0; i < num_icons; i++)
					if (!icon_hidden(i) && sq_dist(c.x_first, c.y_first, i) == best)
						last_idx = i;
				for (int i = 0; i < num_icons; i++)
					if (!icon_hidden(i) && sq_dist(c.x_first, c.y_first, i) == best)
						expect_hit(whtni_pkg::KIND_ICON, i, bit'(i == last_idx));
			end
			default: ;
		endcase
	endtask

	function automatic whtni_pkg::cmd_t make_cmd(whtni_pkg::op_t op, int x1, int y1,
			int x2 = 0, int y2 = 0);
		whtni_pkg::cmd_t c;
		c.operation = op;
		c.x_first = 10'(x1);
		c.y_first = 10'(y1);
		c.x_second = 10'(x2);
		c.y_second = 10'(y2);
		return c;
	endfunction

	function automatic whtni_pkg::cmd_t random_cmd(int area);
		whtni_pkg::cmd_t c;
		int   sel;
		int   x;
		int   y;
		sel = $urandom_range(0, 99);
		x = $urandom_range(0, area);
		y = $urandom_range(0, area);
		if (sel < 35)
			c = make_cmd(whtni_pkg::OP_ADD_ICON, x, y);
		else if (sel < 45)
			c = make_cmd(whtni_pkg::OP_ADD_REGION, x, y, x + int'($urandom_range(0, 40)),
				y + int'($urandom_range(0, 40)));
		else if (sel < 48)
			c = make_cmd(whtni_pkg::OP_ADD_REGION, $urandom, $urandom, $urandom, $urandom);
		else if (sel < 95)
			c = make_cmd(whtni_pkg::OP_CLICK, x, y, $urandom, $urandom);
		else
			c = make_cmd(whtni_pkg::OP_NONE, $urandom, $urandom, $urandom, $urandom);
		return c;
	endfunction

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Stimulus driver: holds start until the beat is taken.
	int gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			gap <= 0;
		end else if (start && !busy) begin
			predict_hits(cmd);
			void'(pending_cmds.pop_front());
			if (!calm && $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				gap <= $urandom_range(0, 4);
			end else if (pending_cmds.size() > 0) begin
				cmd <= pending_cmds[0];
			end else begin
				start <= 1'b0;
			end
		end else if (!start) begin
			if (gap > 0)
				gap <= gap - 1;
			else if (pending_cmds.size() > 0) begin
				start <= 1'b1;
				cmd <= pending_cmds[0];
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_hits.size() == 0) begin
				$error("unexpected result kind %0d index %0d", result.hit_kind,
					result.hit_index);
				errors++;
			end else begin
				whtni_pkg::result_t exp_hit;
				exp_hit = expected_hits.pop_front();
				if (result.hit_kind !== exp_hit.hit_kind) begin
					$error("hit_kind expected %0d actual %0d", exp_hit.hit_kind,
						result.hit_kind);
					errors++;
				end
				if (result.hit_index !== exp_hit.hit_index) begin
					$error("hit_index expected %0d actual %0d", exp_hit.hit_index,
						result.hit_index);
					errors++;
				end
				if (result.last_of_run !== exp_hit.last_of_run) begin
					$error("last_of_run expected %0d actual %0d", exp_hit.last_of_run,
						result.last_of_run);
					errors++;
				end
			end
		end
	end

	initial begin
		#200ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int area;
		errors = 0;
		calm = 1'b0;
		num_icons = 0;
		num_regions = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty stores, edges, ties, inverted region, opcode three.
		queue_cmd(make_cmd(whtni_pkg::OP_CLICK, 0, 0));
		queue_cmd(make_cmd(whtni_pkg::OP_NONE, 1023, 1023, 1023, 1023));
		queue_cmd(make_cmd(whtni_pkg::OP_ADD_ICON, 0, 0));
		queue_cmd(make_cmd(whtni_pkg::OP_ADD_ICON, 1023, 1023));
		queue_cmd(make_cmd(whtni_pkg::OP_ADD_ICON, 10, 0));
		queue_cmd(make_cmd(whtni_pkg::OP_ADD_ICON, 0, 10));
		queue_cmd(make_cmd(whtni_pkg::OP_CLICK, 5, 5));
		queue_cmd(make_cmd(whtni_pkg::OP_CLICK, 1023, 1023));
		queue_cmd(make_cmd(whtni_pkg::OP_CLICK, 1023, 0));
		queue_cmd(make_cmd(whtni_pkg::OP_ADD_REGION, 500, 500, 400, 600));
		queue_cmd(make_cmd(whtni_pkg::OP_CLICK, 450, 550));
		queue_cmd(make_cmd(whtni_pkg::OP_ADD_REGION, 1000, 1000, 1023, 1023));
		queue_cmd(make_cmd(whtni_pkg::OP_CLICK, 1000, 1000));
		queue_cmd(make_cmd(whtni_pkg::OP_CLICK, 1020, 990));
		queue_cmd(make_cmd(whtni_pkg::OP_ADD_REGION, 0, 0, 10, 10));
		queue_cmd(make_cmd(whtni_pkg::OP_CLICK, 10, 10));
		queue_cmd(make_cmd(whtni_pkg::OP_CLICK, 11, 11));
		queue_cmd(make_cmd(whtni_pkg::OP_ADD_REGION, 5, 5, 20, 20));
		queue_cmd(make_cmd(whtni_pkg::OP_CLICK, 7, 7));
		queue_cmd(make_cmd(whtni_pkg::OP_ADD_REGION, 0, 0, 1023, 1023));
		queue_cmd(make_cmd(whtni_pkg::OP_CLICK, 512, 512));
		wait (pending_cmds.size() == 0 && expected_hits.size() == 0);
		repeat (20) @(posedge clk);

		// Random: small clusters give ties and hidden icons, full stores reached.
		for (int k = 0; k < 450; k++) begin
			area = (k % 150 < 100) ? 63 : 1023;
			queue_cmd(random_cmd(area));
		end
		// The last stretch runs with no idle cycles.
		wait (pending_cmds.size() <= 50);
		calm = 1'b1;
		wait (pending_cmds.size() == 0 && expected_hits.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
